// ===== rtl/cpl_pkg.sv =====
// Shared widths, types and latency constants for the closest-points pipeline.
package cpl_pkg;

    localparam int COORD_W  = 32;             // coordinate width
    localparam int FRAC_W   = 16;             // fraction bits
    localparam int THR_W    = 16;             // threshold register width
    localparam int DIFF_W   = COORD_W + 1;    // difference of two coordinates
    localparam int PR_W     = 2 * DIFF_W;     // one difference product
    localparam int DOT_W    = PR_W + 1;       // sum of three products
    localparam int WIDE_W   = 2 * DOT_W;      // denom / numerators
    localparam int PROD_W   = WIDE_W + DOT_W - 34; // numerator times direction
    localparam int CHUNK_W  = 34;             // multiplier digit width
    localparam int MA_CH    = 4;              // digits of the wide operand
    localparam int MB_CH    = 2;              // digits of the narrow operand
    localparam int PP_W     = 2 * CHUNK_W;
    localparam int ROW_W    = MA_CH * CHUNK_W + CHUNK_W;
    localparam int MUL_LAT  = 5;
    localparam int QUO_W    = 36;             // quotient bits, top bit flags overflow
    localparam int REM_W    = PROD_W - 1;
    localparam int DEN_W    = WIDE_W - 1 + QUO_W - 1;
    localparam int LANES    = 8;
    localparam int PIPE_DEPTH = 3 + MUL_LAT + 1 + MUL_LAT + 1 + QUO_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PR_W-1:0]    t_pr;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic [REM_W-1:0]          t_rem;
    typedef logic [DEN_W-1:0]          t_den;
    typedef logic [QUO_W-1:0]          t_quo;

    // geometry carried from the difference stage to the numerator stage
    typedef struct packed {
        t_coord [2:0] p1;
        t_coord [2:0] p3;
        t_diff  [2:0] d21;
        t_diff  [2:0] d43;
        logic         deg;
    } t_geo;

    // per-lane base point and solution flag
    typedef struct packed {
        t_coord [LANES-1:0] base;
        logic               found;
    } t_tail;

    typedef struct packed {
        t_wide den;
        t_tail tail;
    } t_mid;

    typedef struct packed {
        logic [LANES-1:0] sgn;
        t_tail            tail;
    } t_dside;

endpackage

// ===== rtl/cpl_if.sv =====
// Valid/ready channel interfaces for the input points and the result.
interface cpl_in_if import cpl_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord a_start_x;
    t_coord a_start_y;
    t_coord a_start_z;
    t_coord a_end_x;
    t_coord a_end_y;
    t_coord a_end_z;
    t_coord b_start_x;
    t_coord b_start_y;
    t_coord b_start_z;
    t_coord b_end_x;
    t_coord b_end_y;
    t_coord b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

interface cpl_out_if import cpl_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   found;
    t_coord near_a_x;
    t_coord near_a_y;
    t_coord near_a_z;
    t_coord near_b_x;
    t_coord near_b_y;
    t_coord near_b_z;
    t_coord param_a;
    t_coord param_b;

    modport source (
        output valid, found, near_a_x, near_a_y, near_a_z,
               near_b_x, near_b_y, near_b_z, param_a, param_b,
        input  ready
    );
    modport sink (
        input  valid, found, near_a_x, near_a_y, near_a_z,
               near_b_x, near_b_y, near_b_z, param_a, param_b,
        output ready
    );
endinterface

// ===== rtl/cpl_mul.sv =====
// Pipelined signed multiplier, wide by medium operand, built from products of 34-bit digits.
module cpl_mul import cpl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_a,
    input  t_dot  i_b,
    output t_prod o_p
);

    logic [MA_CH*CHUNK_W-1:0] r_ma;
    logic [MB_CH*CHUNK_W-1:0] r_mb;
    logic [PP_W-1:0]          r_pp [MB_CH][MA_CH];
    logic [ROW_W-1:0]         r_row [MB_CH];
    logic [PROD_W-1:0]        r_mag;
    t_prod                    r_p;
    logic [3:0]               r_neg;
    logic [WIDE_W-1:0]        w_ma;
    logic [DOT_W-1:0]         w_mb;
    logic [PROD_W-1:0]        w_row1s;

    assign w_ma    = i_a[WIDE_W-1] ? -i_a : i_a;
    assign w_mb    = i_b[DOT_W-1]  ? -i_b : i_b;
    assign w_row1s = {r_row[1][PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes
            r_ma     <= {{(MA_CH*CHUNK_W-WIDE_W){1'b0}}, w_ma};
            r_mb     <= {{(MB_CH*CHUNK_W-DOT_W){1'b0}}, w_mb};
            r_neg[0] <= i_a[WIDE_W-1] ^ i_b[DOT_W-1];
            // digit products
            for (int j = 0; j < MB_CH; j++) begin
                for (int i = 0; i < MA_CH; i++) begin
                    r_pp[j][i] <= r_ma[i*CHUNK_W +: CHUNK_W] * r_mb[j*CHUNK_W +: CHUNK_W];
                end
            end
            r_neg[1] <= r_neg[0];
            // even and odd digits do not overlap: two concatenations, one add
            for (int j = 0; j < MB_CH; j++) begin
                r_row[j] <= ROW_W'({r_pp[j][2], r_pp[j][0]})
                          + {r_pp[j][3], r_pp[j][1], {CHUNK_W{1'b0}}};
            end
            r_neg[2] <= r_neg[1];
            r_mag    <= r_row[0][PROD_W-1:0] + w_row1s;
            r_neg[3] <= r_neg[2];
            r_p      <= r_neg[3] ? -$signed(r_mag) : $signed(r_mag);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/cpl_div_cell.sv =====
// One restoring-division cell: compare, subtract, pass remainder and divisor on.
module cpl_div_cell import cpl_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_rem i_rem,
    input  t_den i_den,
    input  t_quo i_quo,
    output t_rem o_rem,
    output t_den o_den,
    output t_quo o_quo
);

    logic [DEN_W:0] w_diff;
    logic           w_take;
    t_rem           r_rem;
    t_den           r_den;
    t_quo           r_quo;

    assign w_diff = {{(DEN_W-REM_W+1){1'b0}}, i_rem} - {1'b0, i_den};
    assign w_take = !w_diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_take ? w_diff[REM_W-1:0] : i_rem;
            r_den <= i_den >> 1;
            r_quo <= {i_quo[QUO_W-2:0], w_take};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

// ===== rtl/cpl_div.sv =====
// Divider lane: a row of division cells, one quotient bit per cell.
module cpl_div import cpl_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_rem i_rem,
    input  t_den i_den,
    output t_quo o_quo
);

    t_rem w_rem [QUO_W+1];
    t_den w_den [QUO_W+1];
    t_quo w_quo [QUO_W+1];

    assign w_rem[0] = i_rem;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        cpl_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .o_rem (w_rem[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1])
        );
    end

    assign o_quo = w_quo[QUO_W];

endmodule

// ===== rtl/closest_points_two_lines.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and halts
// only while a finished result waits at the output register.
// Length is set by two wide multiplier rounds and 36 division cells per lane.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the threshold to 1;
// data registers are not reset.
module closest_points_two_lines import cpl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [THR_W-1:0]  i_cfg_data,
    cpl_in_if.sink            i_in,
    cpl_out_if.source         o_out
);

    // dot product index: 0 s1343, 1 s4321, 2 s1321, 3 s4343, 4 s2121
    localparam int M_A [6] = '{4, 1, 0, 2, 0, 1};
    localparam int M_B [6] = '{3, 1, 1, 3, 4, 2};

    logic [THR_W-1:0]      r_thr;
    logic [THR_W-1:0]      w_thr;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_adv;

    // ---------------- stage 1: differences and degenerate directions
    t_coord w_p1 [3], w_p2 [3], w_p3 [3], w_p4 [3];
    t_diff  w_d13 [3];
    t_geo   w_geo;
    logic [DIFF_W-1:0] w_abs21 [3], w_abs43 [3];
    logic   [2:0] w_sm21, w_sm43;
    t_diff  r_d13 [3];
    t_geo   r_geo1, r_geo2, r_geo3;
    t_geo   r_gl [MUL_LAT];

    // ---------------- stages 2..3: products and dot sums
    t_pr    r_pr [15];
    t_dot   r_dot [5];

    // ---------------- wide products, numerators
    t_prod  w_m [6];
    t_wide  w_den, w_numa, w_numb;
    t_wide  r_den, r_numa, r_numb;
    logic   r_found;
    t_geo   r_geo5;
    t_mid   w_mid;
    t_mid   r_ml [MUL_LAT];

    // ---------------- division
    t_prod  w_n [LANES];
    t_rem   r_rem [LANES];
    t_den   r_dd;
    t_dside r_ds0;
    t_dside r_dl [QUO_W];
    t_quo   w_q [LANES];

    // ---------------- result
    logic   r_res_found;
    t_coord r_res [LANES];

    // saturate base + signed clamped quotient to the coordinate range
    function automatic t_coord sat_sum(input logic neg, input t_quo q, input t_coord base);
        logic [QUO_W-1:0]        mag;
        logic signed [QUO_W:0]   sv;
        logic signed [QUO_W+1:0] sum;
        logic [QUO_W+2-COORD_W:0] top;
        t_coord                  res;
        mag = q[QUO_W-1] ? {1'b1, {(QUO_W-1){1'b0}}} : q;
        sv  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        sum = sv + base;
        top = sum[QUO_W+1:COORD_W-1];
        if ((&top) || !(|top)) begin
            res = sum[COORD_W-1:0];
        end else if (sum[QUO_W+1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // threshold register; zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end
    assign w_thr = (r_thr == '0) ? THR_W'(1) : r_thr;

    // single pipeline enable: move whenever the output slot is free or being taken
    assign w_adv      = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // stage 1
    assign w_p1[0] = i_in.a_start_x;  assign w_p2[0] = i_in.a_end_x;
    assign w_p1[1] = i_in.a_start_y;  assign w_p2[1] = i_in.a_end_y;
    assign w_p1[2] = i_in.a_start_z;  assign w_p2[2] = i_in.a_end_z;
    assign w_p3[0] = i_in.b_start_x;  assign w_p4[0] = i_in.b_end_x;
    assign w_p3[1] = i_in.b_start_y;  assign w_p4[1] = i_in.b_end_y;
    assign w_p3[2] = i_in.b_start_z;  assign w_p4[2] = i_in.b_end_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_geo.p1[i]  = w_p1[i];
            w_geo.p3[i]  = w_p3[i];
            w_geo.d21[i] = {w_p2[i][COORD_W-1], w_p2[i]} - {w_p1[i][COORD_W-1], w_p1[i]};
            w_geo.d43[i] = {w_p4[i][COORD_W-1], w_p4[i]} - {w_p3[i][COORD_W-1], w_p3[i]};
            w_d13[i]     = {w_p1[i][COORD_W-1], w_p1[i]} - {w_p3[i][COORD_W-1], w_p3[i]};
            w_abs21[i]   = w_geo.d21[i][DIFF_W-1] ? -w_geo.d21[i] : w_geo.d21[i];
            w_abs43[i]   = w_geo.d43[i][DIFF_W-1] ? -w_geo.d43[i] : w_geo.d43[i];
            w_sm21[i]    = w_abs21[i] < {{(DIFF_W-THR_W){1'b0}}, w_thr};
            w_sm43[i]    = w_abs43[i] < {{(DIFF_W-THR_W){1'b0}}, w_thr};
        end
        // a direction is zero only when every component is small
        w_geo.deg = (&w_sm21) || (&w_sm43);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d13  <= w_d13;
            r_geo1 <= w_geo;
            // stage 2: fifteen component products
            for (int i = 0; i < 3; i++) begin
                r_pr[i]      <= r_d13[i]      * r_geo1.d43[i];
                r_pr[3 + i]  <= r_geo1.d43[i] * r_geo1.d21[i];
                r_pr[6 + i]  <= r_d13[i]      * r_geo1.d21[i];
                r_pr[9 + i]  <= r_geo1.d43[i] * r_geo1.d43[i];
                r_pr[12 + i] <= r_geo1.d21[i] * r_geo1.d21[i];
            end
            r_geo2 <= r_geo1;
            // stage 3: dot products
            for (int k = 0; k < 5; k++) begin
                r_dot[k] <= t_dot'(r_pr[3*k]) + t_dot'(r_pr[3*k + 1]) + t_dot'(r_pr[3*k + 2]);
            end
            r_geo3 <= r_geo2;
            // geometry waits beside the first multiplier round
            r_gl[0] <= r_geo3;
            for (int i = 1; i < MUL_LAT; i++) r_gl[i] <= r_gl[i-1];
        end
    end

    // first round: denominator and numerator terms
    for (genvar g = 0; g < 6; g++) begin : g_m1
        cpl_mul u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   ({{(WIDE_W-DOT_W){r_dot[M_A[g]][DOT_W-1]}}, r_dot[M_A[g]]}),
            .i_b   (r_dot[M_B[g]]),
            .o_p   (w_m[g])
        );
    end

    assign w_den  = w_m[0][WIDE_W-1:0] - w_m[1][WIDE_W-1:0];
    assign w_numa = w_m[2][WIDE_W-1:0] - w_m[3][WIDE_W-1:0];
    assign w_numb = w_m[4][WIDE_W-1:0] - w_m[5][WIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_den   <= w_den;
            r_numa  <= w_numa;
            r_numb  <= w_numb;
            r_geo5  <= r_gl[MUL_LAT-1];
            // denominator near zero also makes the input degenerate
            r_found <= !r_gl[MUL_LAT-1].deg
                    && (w_den >= $signed({{(WIDE_W-THR_W){1'b0}}, w_thr}));
        end
    end

    // second round: lanes 0..2 near_a, 3..5 near_b, 6 param_a, 7 param_b
    for (genvar g = 0; g < LANES; g++) begin : g_m2
        t_wide w_a;
        t_dot  w_b;
        if (g < 3) begin : g_a
            assign w_a = r_numa;
            assign w_b = {{(DOT_W-DIFF_W){r_geo5.d21[g][DIFF_W-1]}}, r_geo5.d21[g]};
        end else if (g < 6) begin : g_b
            assign w_a = r_numb;
            assign w_b = {{(DOT_W-DIFF_W){r_geo5.d43[g-3][DIFF_W-1]}}, r_geo5.d43[g-3]};
        end else begin : g_p
            assign w_a = (g == 6) ? r_numa : r_numb;
            assign w_b = t_dot'(1) <<< FRAC_W;
        end
        cpl_mul u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_a),
            .i_b   (w_b),
            .o_p   (w_n[g])
        );
    end

    always_comb begin
        w_mid.den        = r_den;
        w_mid.tail.found = r_found;
        for (int i = 0; i < 3; i++) begin
            w_mid.tail.base[i]     = r_geo5.p1[i];
            w_mid.tail.base[3 + i] = r_geo5.p3[i];
        end
        w_mid.tail.base[6] = '0;
        w_mid.tail.base[7] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ml[0] <= w_mid;
            for (int i = 1; i < MUL_LAT; i++) r_ml[i] <= r_ml[i-1];
            // division setup: magnitudes, signs, divisor aligned to the top quotient bit
            for (int k = 0; k < LANES; k++) begin
                r_rem[k]     <= w_n[k][PROD_W-1] ? REM_W'(-w_n[k]) : w_n[k][REM_W-1:0];
                r_ds0.sgn[k] <= w_n[k][PROD_W-1];
            end
            r_ds0.tail <= r_ml[MUL_LAT-1].tail;
            r_dd       <= {r_ml[MUL_LAT-1].den[WIDE_W-2:0], {(QUO_W-1){1'b0}}};
            // side data walks beside the division cells
            r_dl[0] <= r_ds0;
            for (int i = 1; i < QUO_W; i++) r_dl[i] <= r_dl[i-1];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_div
        cpl_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (r_rem[g]),
            .i_den (r_dd),
            .o_quo (w_q[g])
        );
    end

    // output register; degenerate items give all-zero fields
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_found <= r_dl[QUO_W-1].tail.found;
            for (int k = 0; k < LANES; k++) begin
                r_res[k] <= r_dl[QUO_W-1].tail.found
                          ? sat_sum(r_dl[QUO_W-1].sgn[k], w_q[k], r_dl[QUO_W-1].tail.base[k])
                          : '0;
            end
        end
    end

    assign o_out.valid    = r_vld[PIPE_DEPTH-1];
    assign o_out.found    = r_res_found;
    assign o_out.near_a_x = r_res[0];
    assign o_out.near_a_y = r_res[1];
    assign o_out.near_a_z = r_res[2];
    assign o_out.near_b_x = r_res[3];
    assign o_out.near_b_y = r_res[4];
    assign o_out.near_b_z = r_res[5];
    assign o_out.param_a  = r_res[6];
    assign o_out.param_b  = r_res[7];

endmodule

// ===== rtl/cpl_chk.sv =====
// Port-level assertions for the closest-points block, bound to the top level.
module cpl_chk import cpl_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_found,
    input t_coord i_near_a_x,
    input t_coord i_near_a_y,
    input t_coord i_near_a_z,
    input t_coord i_near_b_x,
    input t_coord i_near_b_y,
    input t_coord i_near_b_z,
    input t_coord i_param_a,
    input t_coord i_param_b
);

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // input side is open whenever the output slot frees
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input blocked with free output");

    // degenerate result carries zeros
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> (i_near_a_x == 0 && i_near_a_y == 0 && i_near_a_z == 0
            && i_near_b_x == 0 && i_near_b_y == 0 && i_near_b_z == 0
            && i_param_a == 0 && i_param_b == 0))
        else $error("degenerate result not zero");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> ($stable(i_found)
            && $stable(i_near_a_x) && $stable(i_near_a_y) && $stable(i_near_a_z)
            && $stable(i_near_b_x) && $stable(i_near_b_y) && $stable(i_near_b_z)
            && $stable(i_param_a) && $stable(i_param_b)))
        else $error("result changed while stalled");

endmodule

bind closest_points_two_lines cpl_chk u_cpl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_found     (o_out.found),
    .i_near_a_x  (o_out.near_a_x),
    .i_near_a_y  (o_out.near_a_y),
    .i_near_a_z  (o_out.near_a_z),
    .i_near_b_x  (o_out.near_b_x),
    .i_near_b_y  (o_out.near_b_y),
    .i_near_b_z  (o_out.near_b_z),
    .i_param_a   (o_out.param_a),
    .i_param_b   (o_out.param_b)
);

// ===== bench/cpl_checker.sv =====
// Checker for the closest-points block: predicts each result and compares it field by field.
module cpl_checker import cpl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data,
    cpl_in_if                in_ch,
    cpl_out_if               out_ch,
    output int               o_fails,
    output int               o_pending
);
    typedef logic signed [255:0] w_t;

    typedef struct {
        logic   found;
        t_coord v [8];
    } solution_t;

    logic [THR_W-1:0] thr_q;
    solution_t        solutions_due [$];
    int               fails;

    function automatic t_coord clamp32(input w_t v);
        w_t hi;
        w_t lo;
        hi = (w_t'(1) <<< (COORD_W - 1)) - 1;
        lo = -(w_t'(1) <<< (COORD_W - 1));
        if (v > hi) return {1'b0, {(COORD_W-1){1'b1}}};
        if (v < lo) return {1'b1, {(COORD_W-1){1'b0}}};
        return v[COORD_W-1:0];
    endfunction

    function automatic w_t mag(input w_t v);
        return (v < 0) ? -v : v;
    endfunction

    // exact wide-integer form of the closest-point solution
    function automatic solution_t solve_lines(input t_coord c [12], input logic [THR_W-1:0] thr_in);
        solution_t r;
        w_t thr, p1 [3], p3 [3], d13 [3], d43 [3], d21 [3];
        w_t s1343, s4321, s1321, s4343, s2121, denom, numa, numb, one;
        logic flat43, flat21;
        r.found = 1'b0;
        for (int i = 0; i < 8; i++) r.v[i] = '0;
        thr = (thr_in == 0) ? w_t'(1) : w_t'(thr_in);
        flat43 = 1'b1;
        flat21 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p1[i]  = w_t'(c[i]);
            p3[i]  = w_t'(c[6+i]);
            d21[i] = w_t'(c[3+i]) - p1[i];
            d43[i] = w_t'(c[9+i]) - p3[i];
            d13[i] = p1[i] - p3[i];
            if (mag(d43[i]) >= thr) flat43 = 1'b0;
            if (mag(d21[i]) >= thr) flat21 = 1'b0;
        end
        if (flat43 || flat21) return r;
        s1343 = d13[0]*d43[0] + d13[1]*d43[1] + d13[2]*d43[2];
        s4321 = d43[0]*d21[0] + d43[1]*d21[1] + d43[2]*d21[2];
        s1321 = d13[0]*d21[0] + d13[1]*d21[1] + d13[2]*d21[2];
        s4343 = d43[0]*d43[0] + d43[1]*d43[1] + d43[2]*d43[2];
        s2121 = d21[0]*d21[0] + d21[1]*d21[1] + d21[2]*d21[2];
        denom = s2121*s4343 - s4321*s4321;
        if (mag(denom) < thr || denom == 0) return r;
        numa = s1343*s4321 - s1321*s4343;
        numb = s1343*s2121 - s4321*s1321;
        one  = w_t'(1) <<< FRAC_W;
        r.found = 1'b1;
        for (int i = 0; i < 3; i++) begin
            r.v[i]   = clamp32(p1[i] + (numa*d21[i]) / denom);
            r.v[3+i] = clamp32(p3[i] + (numb*d43[i]) / denom);
        end
        r.v[6] = clamp32((numa*one) / denom);
        r.v[7] = clamp32((numb*one) / denom);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) thr_q <= 1;
        else if (i_cfg_we) thr_q <= i_cfg_data;
    end

    // input transfers: predict
    always @(posedge i_clk) begin
        t_coord c [12];
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            c = '{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z,
                  in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z,
                  in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z,
                  in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z};
            solutions_due.push_back(solve_lines(c, thr_q));
        end
    end

    // output transfers: compare against the oldest prediction
    initial fails = 0;
    always @(posedge i_clk) begin
        solution_t e;
        t_coord    got [8];
        string     names [8];
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            names = '{"near_a_x", "near_a_y", "near_a_z", "near_b_x", "near_b_y",
                      "near_b_z", "param_a", "param_b"};
            got = '{out_ch.near_a_x, out_ch.near_a_y, out_ch.near_a_z, out_ch.near_b_x,
                    out_ch.near_b_y, out_ch.near_b_z, out_ch.param_a, out_ch.param_b};
            if (solutions_due.size() == 0) begin
                $error("unexpected result transfer");
                fails++;
            end else begin
                e = solutions_due.pop_front();
                if (out_ch.found !== e.found) begin
                    $error("found: expected %0d, got %0d", e.found, out_ch.found);
                    fails++;
                end
                for (int i = 0; i < 8; i++) begin
                    if (got[i] !== e.v[i]) begin
                        $error("%s: expected %0d, got %0d", names[i], e.v[i], got[i]);
                        fails++;
                    end
                end
            end
        end
    end

    assign o_fails   = fails + solutions_due.size();
    assign o_pending = solutions_due.size();
endmodule

// ===== bench/testbench.sv =====
// Top of the closest-points bench: clock, reset, stimulus, output backpressure and verdict.
module testbench;
    import cpl_pkg::*;

    localparam int LAT       = 52;    // pipeline latency
    localparam int WDOG_MAX  = 3000;  // idle cycles before giving up
    localparam int HOLD_LEN  = 300;   // long output stall, fills the pipe

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_data;
    int               fails;
    int               pending;
    logic             hold_req;
    logic             burst;       // no idling on either side while set
    int               idle_cycles;

    cpl_in_if  in_ch ();
    cpl_out_if out_ch ();

    closest_points_two_lines uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    cpl_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on either channel
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: per-transfer random stall, plus one long hold-off on request
    initial begin
        int wait_n;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            wait_n = burst ? 0 : $urandom_range(0, 7);
            if (wait_n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // one input transfer, after a random gap
    task automatic offer_points(input t_coord c [12]);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.a_start_x <= c[0];
        in_ch.a_start_y <= c[1];
        in_ch.a_start_z <= c[2];
        in_ch.a_end_x   <= c[3];
        in_ch.a_end_y   <= c[4];
        in_ch.a_end_z   <= c[5];
        in_ch.b_start_x <= c[6];
        in_ch.b_start_y <= c[7];
        in_ch.b_start_z <= c[8];
        in_ch.b_end_x   <= c[9];
        in_ch.b_end_y   <= c[10];
        in_ch.b_end_z   <= c[11];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // signed value in +-2^bits
    function automatic t_coord span(input int bits);
        logic [31:0] r;
        r = $urandom;
        return $signed(r << (31 - bits)) >>> (31 - bits);
    endfunction

    // random line pair: mostly well-formed geometry, some raw noise and degenerate shapes
    function automatic void random_lines(output t_coord c [12]);
        int kind;
        int k;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 12; i++) c[i] = span($urandom_range(4, 22));
        if (kind < 15) begin
            for (int i = 0; i < 12; i++) c[i] = $urandom;       // full range
        end else if (kind < 25) begin
            // tiny direction on one line, around the threshold
            for (int i = 0; i < 3; i++)
                if (kind < 20) c[3+i] = c[i] + span($urandom_range(0, 16));
                else c[9+i] = c[6+i] + span($urandom_range(0, 16));
        end else if (kind < 35) begin
            // parallel or nearly parallel lines
            k = $urandom_range(1, 4);
            for (int i = 0; i < 3; i++) begin
                c[3+i] = c[i] + span(12);
                c[9+i] = c[6+i] + k * (c[3+i] - c[i]) + span($urandom_range(0, 2));
            end
        end else if (kind < 42) begin
            // shared start point, lines intersect
            for (int i = 0; i < 3; i++) c[6+i] = c[i];
        end
    endfunction

    task automatic random_phase(input int n_items, input int hold_at);
        t_coord c [12];
        for (int n = 0; n < n_items; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == hold_at) begin
                burst    = 1'b1;    // keep offering while the output is held
                hold_req = 1'b1;
            end
            random_lines(c);
            offer_points(c);
        end
    endtask

    // wait until every prediction is matched, then let the pipe settle
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    localparam t_coord CMAX = 32'sh7fffffff;
    localparam t_coord CMIN = 32'sh80000000;
    localparam t_coord ONE  = 32'sh00010000;

    initial begin
        t_coord dir [16][12];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        burst       = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z} = '0;
        {in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z}       = '0;
        {in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z} = '0;
        {in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z}       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate shapes, extremes, saturation, plain skew lines
        dir[0]  = '{default: 0};                                         // all zero
        dir[1]  = '{0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0, ONE, 2*ONE};     // skew, unit axes
        dir[2]  = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0};         // parallel
        dir[3]  = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                    CMIN, CMIN, CMIN, CMAX, CMAX, CMAX};                 // opposite extremes
        dir[4]  = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                    CMIN, CMIN, CMAX, CMAX, CMAX, CMIN};                 // mixed extremes
        dir[5]  = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0};                 // one-LSB directions
        dir[6]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0};               // first line flat
        dir[7]  = '{0, 0, 0, ONE, 0, 0, 5, 7, 0, 5, 7, 0};               // second line flat
        dir[8]  = '{0, 0, 0, ONE, 0, 0, 32'sh40000000, ONE, 0,
                    32'sh40000000 + ONE, ONE + 1, 0};                    // near parallel, far
        dir[9]  = '{CMIN, 0, 0, CMIN + 1, 0, 0, CMAX, 0, 0, CMAX, 1, 0}; // tiny dirs, huge gap
        dir[10] = '{CMAX, CMAX, CMAX, CMAX - ONE, CMAX, CMAX,
                    CMIN, CMIN, CMIN, CMIN, CMIN + ONE, CMIN};           // corners of space
        dir[11] = '{-ONE, -ONE, -ONE, ONE, ONE, ONE,
                    ONE, -ONE, 0, -ONE, ONE, 0};                         // crossing lines
        dir[12] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 13};              // raw-LSB skew
        dir[13] = '{0, 0, 0, 32'sh7fff0000, 0, 0, 0, 32'sh7fff0000, 1,
                    0, 32'sh7fff0000, 32'sh7fff0000};                    // long lines
        dir[14] = '{-1, -1, -1, 0, -1, -1, -1, -1, 0, -1, 0, 0};         // all-ones bits
        dir[15] = '{32'sh55555555, 32'shaaaaaaaa, 32'sh33333333, 32'shcccccccc,
                    32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff, 32'shff00ff00,
                    32'h12345678, 32'sh87654321, 32'sh7f7f7f7f, 32'sh80808080};
        for (int i = 0; i < 16; i++) offer_points(dir[i]);

        // threshold at reset value, then zero (acts as one), max, and a random setting
        random_phase(400, -1);
        set_threshold('0);
        for (int i = 0; i < 8; i++) offer_points(dir[i]);
        random_phase(340, -1);
        set_threshold({THR_W{1'b1}});
        for (int i = 0; i < 8; i++) offer_points(dir[i]);
        random_phase(340, -1);
        set_threshold($urandom_range(2, 65534));
        random_phase(440, 120);

        drain();
        if (fails == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
